### hw/rtl/sfw_pkg.sv
// ----------------------------------------------------------------------------
// sfw_pkg
// Shared constants, codes and types of the STFT frame windower.
// ----------------------------------------------------------------------------
package sfw_pkg;

  localparam int MAX_WINDOW = 64;
  localparam int RING_AW    = $clog2(MAX_WINDOW);
  localparam int CNT_W      = 7;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int QCNT_W     = FIFO_AW + 1;

  typedef enum logic {
    FUNC_SAMPLE = 1'b0,
    FUNC_COEF   = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    REG_WIN_LEN = 2'd0,
    REG_HOP     = 2'd1,
    REG_GAIN    = 2'd2
  } reg_idx_e;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [6:0]  win_len;
    logic [6:0]  hop;
    logic [23:0] gain;
  } cfg_t;

  typedef struct packed {
    logic sample_we;
    logic coef_we;
    logic frame_start;
    logic issue;
  } cmd_t;

  typedef struct packed {
    logic emit_now;
    logic credit_ok;
    logic last_tap;
  } status_t;

endpackage

### hw/rtl/sfw_regs.sv
// ----------------------------------------------------------------------------
// sfw_regs
// APB register file: window size, hop and gain.
// ----------------------------------------------------------------------------
module sfw_regs
  import sfw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t       cfg_q;
  cfg_t       cfg_d;
  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_WIN_LEN: cfg_d.win_len = pwdata[6:0];
        REG_HOP:     cfg_d.hop     = pwdata[6:0];
        REG_GAIN:    cfg_d.gain    = pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_WIN_LEN: prdata = {25'd0, cfg_q.win_len};
      REG_HOP:     prdata = {25'd0, cfg_q.hop};
      REG_GAIN:    prdata = {8'd0, cfg_q.gain};
      default:     prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.win_len <= 7'd64;
      cfg_q.hop     <= 7'd32;
      cfg_q.gain    <= 24'd65536;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hw/rtl/sfw_ctrl.sv
// ----------------------------------------------------------------------------
// sfw_ctrl
// Sequencer: takes input transactions and steps through the taps of a frame.
// ----------------------------------------------------------------------------
module sfw_ctrl
  import sfw_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    func_i,
  output logic    in_stall_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q;
  state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (func_i == FUNC_COEF) begin
            cmd_o.coef_we = 1'b1;
          end else begin
            cmd_o.sample_we = 1'b1;
            if (status_i.emit_now) begin
              cmd_o.frame_start = 1'b1;
              state_d           = ST_EMIT;
            end
          end
        end
      end
      ST_EMIT: begin
        in_stall_o  = 1'b1;
        cmd_o.issue = status_i.credit_ok;
        if (status_i.credit_ok && status_i.last_tap) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_issue_needs_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.issue |-> status_i.credit_ok)
    else $error("tap issued without queue credit");
  a_last_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.issue && status_i.last_tap |=> !cmd_o.issue && !in_stall_o)
    else $error("sequencer did not release after last tap");
  a_frame_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.frame_start |=> state_q == ST_EMIT && !cmd_o.sample_we)
    else $error("frame start did not enter emission");
`endif

endmodule

### hw/rtl/sfw_dp.sv
// ----------------------------------------------------------------------------
// sfw_dp
// Datapath: sample ring, coefficient table, frame counters, windowing
// multiply pipeline and output queue.
// ----------------------------------------------------------------------------
module sfw_dp
  import sfw_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  cmd_t                cmd_i,
  output status_t             status_o,
  input  logic signed [15:0]  sample_in_i,
  input  logic [5:0]          coef_index_i,
  input  logic signed [17:0]  coef_value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [15:0]  windowed_o,
  output logic [5:0]          tap_pos_o,
  output logic                frame_end_o
);

  localparam logic [CNT_W-1:0] MaxN     = CNT_W'(MAX_WINDOW);
  localparam logic [CNT_W-1:0] SinceTop = {CNT_W{1'b1}};
  localparam int               PW       = RING_AW + 2;

  logic signed [15:0] ring_mem [MAX_WINDOW];
  logic signed [17:0] coef_mem [MAX_WINDOW];

  logic [RING_AW-1:0] wp_q, wp_d, start_q, start_d, x_q, slot;
  logic [CNT_W-1:0]   fill_q, fill_d, since_q, since_d, n_q, n_eff, h_eff;
  logic [CNT_W-1:0]   fill_inc, since_inc;
  logic               emit;
  logic [PW-1:0]      start_sum, slot_sum;

  // counters and emission decision
  always_comb begin
    if (cfg_i.win_len < CNT_W'(2)) begin
      n_eff = CNT_W'(2);
    end else if (cfg_i.win_len > MaxN) begin
      n_eff = MaxN;
    end else begin
      n_eff = cfg_i.win_len;
    end
    h_eff     = (cfg_i.hop == '0) ? CNT_W'(1) : cfg_i.hop;
    fill_inc  = fill_q + CNT_W'(1);
    since_inc = (since_q == SinceTop) ? since_q : since_q + CNT_W'(1);
    wp_d      = (wp_q == RING_AW'(MAX_WINDOW - 1)) ? '0 : wp_q + RING_AW'(1);
    fill_d    = fill_q;
    since_d   = since_q;
    if (fill_q < n_eff) begin
      fill_d = fill_inc;
      emit   = (fill_inc == n_eff);
    end else begin
      since_d = since_inc;
      emit    = (since_inc >= h_eff);
    end
    if (emit) begin
      since_d = '0;
    end
    start_sum = PW'(wp_d) + PW'(MAX_WINDOW) - PW'(n_eff);
    if (start_sum >= PW'(MAX_WINDOW)) begin
      start_sum = start_sum - PW'(MAX_WINDOW);
    end
    start_d = start_sum[RING_AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      fill_q  <= '0;
      since_q <= '0;
      x_q     <= '0;
      n_q     <= MaxN;
      start_q <= '0;
    end else begin
      if (cmd_i.sample_we) begin
        wp_q    <= wp_d;
        fill_q  <= fill_d;
        since_q <= since_d;
      end
      if (cmd_i.frame_start) begin
        n_q     <= n_eff;
        start_q <= start_d;
        x_q     <= '0;
      end else if (cmd_i.issue) begin
        x_q <= x_q + RING_AW'(1);
      end
    end
  end

  always_comb begin
    slot_sum = PW'(start_q) + PW'(x_q);
    if (slot_sum >= PW'(MAX_WINDOW)) begin
      slot_sum = slot_sum - PW'(MAX_WINDOW);
    end
    slot = slot_sum[RING_AW-1:0];
  end

  // memories
  logic signed [15:0] s1_q;
  logic signed [17:0] c1_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sample_we) begin
      ring_mem[wp_q] <= sample_in_i;
    end
    s1_q <= ring_mem[slot];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.coef_we && ({1'b0, coef_index_i} < (RING_AW + 1)'(MAX_WINDOW))) begin
      coef_mem[coef_index_i[RING_AW-1:0]] <= coef_value_i;
    end
    c1_q <= coef_mem[x_q];
  end

  // multiply pipeline
  logic               v1_q, v2_q, v3_q, v4_q;
  logic               last_now, l1_q, l2_q, l3_q, l4_q;
  logic [5:0]         t1_q, t2_q, t3_q, t4_q;
  logic signed [33:0] p2_q;
  logic signed [46:0] plo3_q, phi3_q;
  logic signed [58:0] sum_w;
  logic signed [28:0] q4_q;
  logic signed [12:0] g_lo, g_hi;

  assign last_now = ({1'b0, x_q} == n_q - CNT_W'(1));
  assign g_lo     = signed'({1'b0, cfg_i.gain[11:0]});
  assign g_hi     = signed'({1'b0, cfg_i.gain[23:12]});
  assign sum_w    = (59'(phi3_q) <<< 12) + 59'(plo3_q) + 59'(64'sd536870912);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    t1_q   <= 6'(x_q);
    l1_q   <= last_now;
    t2_q   <= t1_q;
    l2_q   <= l1_q;
    p2_q   <= 34'(s1_q) * 34'(c1_q);
    t3_q   <= t2_q;
    l3_q   <= l2_q;
    plo3_q <= 47'(p2_q) * 47'(g_lo);
    phi3_q <= 47'(p2_q) * 47'(g_hi);
    t4_q   <= t3_q;
    l4_q   <= l3_q;
    q4_q   <= 29'(sum_w >>> 30);
  end

  logic signed [15:0] sat_w;

  always_comb begin
    if (q4_q > 29'sd32767) begin
      sat_w = 16'sh7fff;
    end else if (q4_q < -29'sd32768) begin
      sat_w = 16'sh8000;
    end else begin
      sat_w = q4_q[15:0];
    end
  end

  // output queue
  logic signed [15:0] qw_mem [FIFO_DEPTH];
  logic [5:0]         qt_mem [FIFO_DEPTH];
  logic               qe_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] qwp_q, qrp_q;
  logic [QCNT_W-1:0]  qcnt_q, inflight;
  logic               push, pop;

  assign push = v4_q;
  assign pop  = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      qw_mem[qwp_q] <= sat_w;
      qt_mem[qwp_q] <= t4_q;
      qe_mem[qwp_q] <= l4_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qwp_q  <= '0;
      qrp_q  <= '0;
      qcnt_q <= '0;
    end else begin
      if (push) begin
        qwp_q <= qwp_q + FIFO_AW'(1);
      end
      if (pop) begin
        qrp_q <= qrp_q + FIFO_AW'(1);
      end
      qcnt_q <= qcnt_q + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  assign inflight    = QCNT_W'(v1_q) + QCNT_W'(v2_q) + QCNT_W'(v3_q) + QCNT_W'(v4_q);
  assign out_valid_o = (qcnt_q != '0);
  assign windowed_o  = qw_mem[qrp_q];
  assign tap_pos_o   = qt_mem[qrp_q];
  assign frame_end_o = qe_mem[qrp_q];

  assign status_o.emit_now  = emit;
  assign status_o.credit_ok = (qcnt_q + inflight) < QCNT_W'(FIFO_DEPTH);
  assign status_o.last_tap  = last_now;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && !pop && qcnt_q == QCNT_W'(FIFO_DEPTH)))
    else $error("output queue overflow");
  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (qcnt_q + inflight) <= QCNT_W'(FIFO_DEPTH))
    else $error("queue plus pipeline exceeds depth");
  a_last_tap_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue && last_now |=> v1_q && l1_q && ({1'b0, t1_q} == n_q - CNT_W'(1)))
    else $error("frame end tag lost");
`endif

endmodule

### hw/rtl/stft_frame_windower.sv
// ----------------------------------------------------------------------------
// stft_frame_windower
// Framing and windowing stage of a short-time Fourier analysis.
// ----------------------------------------------------------------------------
// A sample or coefficient load is taken without stall while the sequencer is
// idle. A sample that completes a frame holds off input until every window tap
// is read; the sequencer reads one tap per cycle from the single read port of
// the sample ring and coefficient table, and waits when the output queue has no
// room. Results pass through the read, product, gain and rounding registers
// into an eight-entry queue and leave it one per cycle when the consumer does
// not stall. The sample ring needs no clearing after reset; only its written
// entries are used. The coefficient table is not cleared, and the block does
// not check that the coefficients of a frame's taps were written.
// ----------------------------------------------------------------------------
module stft_frame_windower
  import sfw_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               func_i,
  input  logic signed [15:0] sample_in_i,
  input  logic [5:0]         coef_index_i,
  input  logic signed [17:0] coef_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] windowed_o,
  output logic [5:0]         tap_pos_o,
  output logic               frame_end_o
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  sfw_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sfw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sfw_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .status_o     (status),
    .sample_in_i  (sample_in_i),
    .coef_index_i (coef_index_i),
    .coef_value_i (coef_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .windowed_o   (windowed_o),
    .tap_pos_o    (tap_pos_o),
    .frame_end_o  (frame_end_o)
  );

endmodule
